### hdl/atac_pkg.sv
// Shared types, widths and the CORDIC angle table for the tilt angle core.
// No dependencies; every other file imports this package.
package atac_pkg;
	localparam int AXIS_W = 16;
	localparam int CORR_W = 12;
	localparam int SQ_W = 23;
	localparam int M_W = 24;
	localparam int SQRT_BITS = 28;
	localparam int REM_W = 58;
	localparam int CW = 32;
	localparam int ZW = 25;
	localparam int ANG_W = 14;
	localparam int ANGLE_LIMIT = 5760;
	localparam int ATAN_ENTRIES = 24;
	localparam int IDX_W = 2;

	localparam logic [IDX_W-1:0] REG_OFFSET_X = 2'd0;
	localparam logic [IDX_W-1:0] REG_OFFSET_Y = 2'd1;
	localparam logic [IDX_W-1:0] REG_OFFSET_Z = 2'd2;

	typedef struct packed {
		logic signed [CORR_W-1:0] cx;
		logic signed [CORR_W-1:0] cy;
		logic signed [CORR_W-1:0] cz;
		logic                     zero;
	} side_t;

	typedef struct packed {
		side_t          side;
		logic [M_W-1:0] mx;
		logic [M_W-1:0] my;
		logic [M_W-1:0] mz;
	} qent_t;

	function automatic logic signed [ZW-1:0] atac_atan(input int i);
		logic signed [ZW-1:0] v;
		case (i)
			0: v = 25'sd2949120;
			1: v = 25'sd1740967;
			2: v = 25'sd919879;
			3: v = 25'sd466945;
			4: v = 25'sd234379;
			5: v = 25'sd117304;
			6: v = 25'sd58666;
			7: v = 25'sd29335;
			8: v = 25'sd14668;
			9: v = 25'sd7334;
			10: v = 25'sd3667;
			11: v = 25'sd1833;
			12: v = 25'sd917;
			13: v = 25'sd458;
			14: v = 25'sd229;
			15: v = 25'sd115;
			16: v = 25'sd57;
			17: v = 25'sd29;
			18: v = 25'sd14;
			19: v = 25'sd7;
			20: v = 25'sd4;
			21: v = 25'sd2;
			22: v = 25'sd1;
			default: v = '0;
		endcase
		return v;
	endfunction
endpackage

### hdl/atac_front.sv
// Front end: offset registers, offset correction, zero detect and squares.
// Depends on atac_pkg.
module atac_front import atac_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     take,
	input  logic signed [AXIS_W-1:0] raw_x,
	input  logic signed [AXIS_W-1:0] raw_y,
	input  logic signed [AXIS_W-1:0] raw_z,
	input  logic                     cfg_we,
	input  logic [IDX_W-1:0]         cfg_index,
	input  logic [AXIS_W-1:0]        cfg_data,
	output logic                     push,
	output qent_t                    ent
);
	logic [AXIS_W-1:0] off_x_q, off_y_q, off_z_q;
	logic [AXIS_W-1:0] dx, dy, dz;
	logic vld_s1, vld_s2;
	side_t side_s1, side_s2;
	logic [SQ_W-1:0] sx_s2, sy_s2, sz_s2;
	logic signed [2*CORR_W-1:0] px, py, pz;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_x_q <= '0;
			off_y_q <= '0;
			off_z_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_OFFSET_X: off_x_q <= cfg_data;
				REG_OFFSET_Y: off_y_q <= cfg_data;
				REG_OFFSET_Z: off_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign dx = raw_x - off_x_q;
	assign dy = raw_y - off_y_q;
	assign dz = raw_z - off_z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= take;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		side_s1.cx   <= dx[AXIS_W-1:4];
		side_s1.cy   <= dy[AXIS_W-1:4];
		side_s1.cz   <= dz[AXIS_W-1:4];
		side_s1.zero <= (dx[AXIS_W-1:4] == '0) && (dy[AXIS_W-1:4] == '0)
			&& (dz[AXIS_W-1:4] == '0);
	end

	assign px = side_s1.cx * side_s1.cx;
	assign py = side_s1.cy * side_s1.cy;
	assign pz = side_s1.cz * side_s1.cz;

	always_ff @(posedge clk) begin
		side_s2 <= side_s1;
		sx_s2   <= px[SQ_W-1:0];
		sy_s2   <= py[SQ_W-1:0];
		sz_s2   <= pz[SQ_W-1:0];
	end

	assign push     = vld_s2;
	assign ent.side = side_s2;
	assign ent.mx   = {1'b0, sy_s2} + {1'b0, sz_s2};
	assign ent.my   = {1'b0, sx_s2} + {1'b0, sz_s2};
	assign ent.mz   = {1'b0, sx_s2} + {1'b0, sy_s2};
endmodule

### hdl/atac_queue.sv
// Two-entry request queue between the front end and the angle back end.
// Depends on atac_pkg.
module atac_queue import atac_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  qent_t wr_ent,
	input  logic  pop,
	output qent_t rd_ent,
	output logic  empty,
	output logic  full
);
	qent_t mem_q [0:1];
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic do_push, do_pop;

	assign empty   = (cnt_q == 2'd0);
	assign full    = (cnt_q == 2'd2);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_ent  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= !wr_ptr_q;
			if (do_pop) rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end
endmodule

### hdl/atac_sqrt.sv
// Pipelined bit-per-stage integer square root of m * 2^32.
// Depends on atac_pkg.
module atac_sqrt import atac_pkg::*; (
	input  logic                     clk,
	input  logic [M_W-1:0]           m,
	input  logic signed [CORR_W-1:0] a_in,
	output logic [SQRT_BITS-1:0]     root,
	output logic signed [CORR_W-1:0] a_out
);
	logic [REM_W-1:0] rem_q [0:SQRT_BITS-1];
	logic [SQRT_BITS-1:0] res_q [0:SQRT_BITS-1];
	logic signed [CORR_W-1:0] a_q [0:SQRT_BITS-1];

	for (genvar j = 0; j < SQRT_BITS; j++) begin : g_stage
		localparam int K = SQRT_BITS - 1 - j;
		logic [REM_W-1:0] rem_in, trial;
		logic [SQRT_BITS-1:0] res_in;
		logic signed [CORR_W-1:0] a_src;
		if (j == 0) begin : g_first
			assign rem_in = {{(REM_W-M_W-32){1'b0}}, m, 32'd0};
			assign res_in = '0;
			assign a_src  = a_in;
		end else begin : g_next
			assign rem_in = rem_q[j-1];
			assign res_in = res_q[j-1];
			assign a_src  = a_q[j-1];
		end
		assign trial = ({{(REM_W-SQRT_BITS){1'b0}}, res_in} << (K + 1))
			+ ({{(REM_W-1){1'b0}}, 1'b1} << (2 * K));
		always_ff @(posedge clk) begin
			a_q[j] <= a_src;
			if (rem_in >= trial) begin
				rem_q[j] <= rem_in - trial;
				res_q[j] <= res_in | (SQRT_BITS'(1) << K);
			end else begin
				rem_q[j] <= rem_in;
				res_q[j] <= res_in;
			end
		end
	end

	assign root  = res_q[SQRT_BITS-1];
	assign a_out = a_q[SQRT_BITS-1];
endmodule

### hdl/atac_cordic.sv
// Pipelined vectoring CORDIC giving atan2(a, root) in 1/64 degree, saturated.
// Depends on atac_pkg.
module atac_cordic import atac_pkg::*; #(
	parameter int ITER = 16
) (
	input  logic                     clk,
	input  logic [SQRT_BITS-1:0]     root,
	input  logic signed [CORR_W-1:0] a,
	output logic signed [ANG_W-1:0]  angle
);
	logic signed [CW-1:0] x_q [0:ITER-1];
	logic signed [CW-1:0] y_q [0:ITER-1];
	logic signed [ZW-1:0] z_q [0:ITER-1];
	logic signed [ZW:0] zr;
	logic signed [ZW-10:0] r;

	for (genvar i = 0; i < ITER; i++) begin : g_stage
		logic signed [CW-1:0] xs, ys;
		logic signed [ZW-1:0] zs;
		logic signed [ZW-1:0] da;
		if (i == 0) begin : g_first
			assign xs = CW'(root);
			assign ys = {{(CW-CORR_W-16){a[CORR_W-1]}}, a, 16'd0};
			assign zs = '0;
		end else begin : g_next
			assign xs = x_q[i-1];
			assign ys = y_q[i-1];
			assign zs = z_q[i-1];
		end
		assign da = atac_atan(i);
		always_ff @(posedge clk) begin
			if (!ys[CW-1]) begin
				x_q[i] <= xs + (ys >>> i);
				y_q[i] <= ys - (xs >>> i);
				z_q[i] <= zs + da;
			end else begin
				x_q[i] <= xs - (ys >>> i);
				y_q[i] <= ys + (xs >>> i);
				z_q[i] <= zs - da;
			end
		end
	end

	assign zr = {z_q[ITER-1][ZW-1], z_q[ITER-1]} + (ZW+1)'(512);
	assign r  = zr[ZW:10];

	always_comb begin
		if (r > (ZW-9)'(ANGLE_LIMIT)) begin
			angle = ANG_W'(ANGLE_LIMIT);
		end else if (r < -(ZW-9)'(ANGLE_LIMIT)) begin
			angle = -ANG_W'(ANGLE_LIMIT);
		end else begin
			angle = r[ANG_W-1:0];
		end
	end
endmodule

### hdl/accel_tilt_angle_compute_core.sv
// Top level of the accelerometer tilt angle core: front end, queue, root and CORDIC back end.
// Depends on atac_pkg, atac_front, atac_queue, atac_sqrt and atac_cordic.
//
// Channel   | Ports                                   | Handshake
// request   | start, busy, raw_x/y/z                  | taken when start && !busy
// result    | done, corrected_x/y/z, *_angle, zero_v. | valid for one cycle with done
// config    | cfg_we, cfg_index, cfg_data             | written when cfg_we
//
// One request is taken per cycle; each result passes from the edge that takes it through
// two front-end stages, the queue register, the 28-stage square root
// pipeline, one CORDIC stage per iteration and the output register.
// Reset clears offsets and all valid flags. The receiver cannot stall, so busy stays low.
module accel_tilt_angle_compute_core import atac_pkg::*; #(
	parameter int CORDIC_ITERATIONS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic signed [AXIS_W-1:0] raw_x,
	input  logic signed [AXIS_W-1:0] raw_y,
	input  logic signed [AXIS_W-1:0] raw_z,
	input  logic                     cfg_we,
	input  logic [IDX_W-1:0]         cfg_index,
	input  logic [AXIS_W-1:0]        cfg_data,
	output logic                     done,
	output logic signed [CORR_W-1:0] corrected_x,
	output logic signed [CORR_W-1:0] corrected_y,
	output logic signed [CORR_W-1:0] corrected_z,
	output logic signed [ANG_W-1:0]  pitch_angle,
	output logic signed [ANG_W-1:0]  roll_angle,
	output logic signed [ANG_W-1:0]  yaw_angle,
	output logic                     zero_vector
);
	localparam int DLY = SQRT_BITS + CORDIC_ITERATIONS;

	logic push, empty, full, pop;
	qent_t wr_ent, rd_ent;
	logic [SQRT_BITS-1:0] rt_x, rt_y, rt_z;
	logic signed [CORR_W-1:0] ax, ay, az;
	logic signed [ANG_W-1:0] ang_x, ang_y, ang_z;
	side_t side_q [0:DLY-1];
	logic [DLY-1:0] vld_q;
	side_t side_o;

	assign busy = full;
	assign pop  = !empty;

	atac_front u_front (
		.clk(clk), .arst_n(arst_n), .take(start && !busy),
		.raw_x(raw_x), .raw_y(raw_y), .raw_z(raw_z),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.push(push), .ent(wr_ent)
	);

	atac_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .wr_ent(wr_ent),
		.pop(pop), .rd_ent(rd_ent), .empty(empty), .full(full)
	);

	atac_sqrt u_sqrt_x (.clk(clk), .m(rd_ent.mx), .a_in(rd_ent.side.cx),
		.root(rt_x), .a_out(ax));
	atac_sqrt u_sqrt_y (.clk(clk), .m(rd_ent.my), .a_in(rd_ent.side.cy),
		.root(rt_y), .a_out(ay));
	atac_sqrt u_sqrt_z (.clk(clk), .m(rd_ent.mz), .a_in(rd_ent.side.cz),
		.root(rt_z), .a_out(az));

	atac_cordic #(.ITER(CORDIC_ITERATIONS)) u_cordic_x (.clk(clk), .root(rt_x), .a(ax),
		.angle(ang_x));
	atac_cordic #(.ITER(CORDIC_ITERATIONS)) u_cordic_y (.clk(clk), .root(rt_y), .a(ay),
		.angle(ang_y));
	atac_cordic #(.ITER(CORDIC_ITERATIONS)) u_cordic_z (.clk(clk), .root(rt_z), .a(az),
		.angle(ang_z));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			done  <= 1'b0;
		end else begin
			vld_q <= {vld_q[DLY-2:0], pop};
			done  <= vld_q[DLY-1];
		end
	end

	always_ff @(posedge clk) begin
		side_q[0] <= rd_ent.side;
		for (int i = 1; i < DLY; i++) begin
			side_q[i] <= side_q[i-1];
		end
	end

	assign side_o = side_q[DLY-1];

	always_ff @(posedge clk) begin
		corrected_x <= side_o.cx;
		corrected_y <= side_o.cy;
		corrected_z <= side_o.cz;
		zero_vector <= side_o.zero;
		pitch_angle <= side_o.zero ? '0 : ang_x;
		roll_angle  <= side_o.zero ? '0 : -ang_y;
		yaw_angle   <= side_o.zero ? '0 : ang_z;
	end
endmodule

### tb/accel_tilt_angle_compute_core_chk.sv
`timescale 1ns / 1ps
// Checker for the tilt angle core: tracks offset writes, predicts each result from the
// accepted request and compares it with what the core returns. Depends on atac_pkg.
module accel_tilt_angle_compute_core_chk import atac_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic                     busy,
	input  logic signed [AXIS_W-1:0] raw_x,
	input  logic signed [AXIS_W-1:0] raw_y,
	input  logic signed [AXIS_W-1:0] raw_z,
	input  logic                     cfg_we,
	input  logic [IDX_W-1:0]         cfg_index,
	input  logic [AXIS_W-1:0]        cfg_data,
	input  logic                     done,
	input  logic signed [CORR_W-1:0] corrected_x,
	input  logic signed [CORR_W-1:0] corrected_y,
	input  logic signed [CORR_W-1:0] corrected_z,
	input  logic signed [ANG_W-1:0]  pitch_angle,
	input  logic signed [ANG_W-1:0]  roll_angle,
	input  logic signed [ANG_W-1:0]  yaw_angle,
	input  logic                     zero_vector,
	output int                       fails,
	output int                       pending
);
	localparam int STEPS = 16;

	typedef struct packed {
		logic signed [CORR_W-1:0] cx;
		logic signed [CORR_W-1:0] cy;
		logic signed [CORR_W-1:0] cz;
		logic signed [ANG_W-1:0]  pitch;
		logic signed [ANG_W-1:0]  roll;
		logic signed [ANG_W-1:0]  yaw;
		logic                     zero;
	} tilt_t;

	const longint arctan_q16[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
		58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};

	logic signed [AXIS_W-1:0] off_x, off_y, off_z;
	tilt_t tilt_q[$];

	assign pending = tilt_q.size();

	function automatic longint unsigned int_root(input longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic longint vector_angle(input longint a, input longint unsigned m);
		longint vx, vy, acc, dx, dy, r;
		vx = longint'(int_root(m << 32));
		vy = a * 65536;
		acc = 0;
		for (int i = 0; i < STEPS; i++) begin
			dx = vy >>> i;
			dy = vx >>> i;
			if (vy >= 0) begin
				vx += dx; vy -= dy; acc += arctan_q16[i];
			end else begin
				vx -= dx; vy += dy; acc -= arctan_q16[i];
			end
		end
		r = (acc + 512) >>> 10;
		if (r > ANGLE_LIMIT) r = ANGLE_LIMIT;
		if (r < -ANGLE_LIMIT) r = -ANGLE_LIMIT;
		return r;
	endfunction

	function automatic tilt_t tilt_of(input logic signed [AXIS_W-1:0] rx, ry, rz);
		tilt_t t;
		logic signed [AXIS_W-1:0] dx, dy, dz;
		longint x, y, z;
		dx = rx - off_x;
		dy = ry - off_y;
		dz = rz - off_z;
		x = longint'(dx >>> 4);
		y = longint'(dy >>> 4);
		z = longint'(dz >>> 4);
		t.cx = x[CORR_W-1:0];
		t.cy = y[CORR_W-1:0];
		t.cz = z[CORR_W-1:0];
		t.zero = (x == 0 && y == 0 && z == 0);
		t.pitch = '0;
		t.roll = '0;
		t.yaw = '0;
		if (!t.zero) begin
			t.pitch = ANG_W'(vector_angle(x, y * y + z * z));
			t.roll = ANG_W'(-vector_angle(y, x * x + z * z));
			t.yaw = ANG_W'(vector_angle(z, x * x + y * y));
		end
		return t;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		tilt_t want, got;
		if (!arst_n) begin
			off_x <= '0;
			off_y <= '0;
			off_z <= '0;
			fails = 0;
			tilt_q.delete();
		end else begin
			if (done) begin
				got = '{corrected_x, corrected_y, corrected_z, pitch_angle, roll_angle,
					yaw_angle, zero_vector};
				if (tilt_q.size() == 0) begin
					fails++;
					if (fails <= 10) $display("result with no request pending: %p", got);
				end else begin
					want = tilt_q.pop_front();
					if (got !== want) begin
						fails++;
						if (fails <= 10) $display("mismatch: expected %p, got %p", want, got);
					end
				end
			end
			if (start && !busy) tilt_q.push_back(tilt_of(raw_x, raw_y, raw_z));
			if (cfg_we) begin
				case (cfg_index)
					REG_OFFSET_X: off_x <= cfg_data;
					REG_OFFSET_Y: off_y <= cfg_data;
					REG_OFFSET_Z: off_z <= cfg_data;
					default: ;
				endcase
			end
		end
	end
endmodule

### tb/accel_tilt_angle_compute_core_tb.sv
`timescale 1ns / 1ps
// Top of the tilt angle core testbench: clock, reset, offset settings and request stimulus.
// Depends on atac_pkg, the core and accel_tilt_angle_compute_core_chk.
module accel_tilt_angle_compute_core_tb;
	import atac_pkg::*;

	localparam int CYCLE_LIMIT = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic signed [AXIS_W-1:0] raw_x = '0, raw_y = '0, raw_z = '0;
	logic cfg_we = 1'b0;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [AXIS_W-1:0] cfg_data = '0;
	logic busy, done, zero_vector;
	logic signed [CORR_W-1:0] corrected_x, corrected_y, corrected_z;
	logic signed [ANG_W-1:0] pitch_angle, roll_angle, yaw_angle;
	int fails, pending, cycles, sent, burst_left;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	accel_tilt_angle_compute_core i_dut (.*);
	accel_tilt_angle_compute_core_chk i_chk (.*);

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("accel_tilt_angle_compute_core_tb: errors");
			$finish;
		end
	end

	task automatic write_offset(input logic [IDX_W-1:0] idx, input logic [AXIS_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic settle();
		start <= 1'b0;
		wait (pending == 0);
		repeat (60) @(posedge clk);
	endtask

	task automatic set_offsets(input logic [AXIS_W-1:0] ox, oy, oz);
		settle();
		write_offset(REG_OFFSET_X, ox);
		write_offset(REG_OFFSET_Y, oy);
		write_offset(REG_OFFSET_Z, oz);
	endtask

	task automatic send(input logic [AXIS_W-1:0] x, y, z);
		if (burst_left == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
		end
		burst_left--;
		start <= 1'b1;
		raw_x <= x;
		raw_y <= y;
		raw_z <= z;
		do @(posedge clk); while (busy);
		sent++;
	endtask

	function automatic logic [AXIS_W-1:0] rand_axis();
		case ($urandom_range(0, 3))
			0: return AXIS_W'($urandom_range(0, 95)) - 16'd48;
			1: return AXIS_W'($urandom_range(0, 8191)) - 16'd4096;
			default: return AXIS_W'($urandom);
		endcase
	endfunction

	task automatic random_phase(input int n);
		for (int i = 0; i < n; i++) send(rand_axis(), rand_axis(), rand_axis());
	endtask

	initial begin
		burst_left = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send(16'h0000, 16'h0000, 16'h0000);
		send(16'h000F, 16'hFFF1, 16'h0008);
		send(16'h7FFF, 16'h7FFF, 16'h7FFF);
		send(16'h8000, 16'h8000, 16'h8000);
		send(16'h7FFF, 16'h8000, 16'h0000);
		send(16'h0010, 16'h0000, 16'h0000);
		send(16'h0000, 16'hFFF0, 16'h0000);
		send(16'h0000, 16'h0000, 16'h8000);
		send(16'h8000, 16'h0000, 16'h0000);
		send(16'h0000, 16'h7FFF, 16'h0000);
		send(16'h0000, 16'h0000, 16'h0010);
		send(16'h4000, 16'h4000, 16'h0000);
		send(16'hFFFF, 16'h5555, 16'hAAAA);
		set_offsets(16'h8000, 16'h7FFF, 16'h4000);
		send(16'h7FFF, 16'h8000, 16'h0000);
		send(16'h8000, 16'h7FFF, 16'h4000);
		send(16'h0000, 16'hFFFF, 16'hC000);
		settle();
		write_offset(2'd3, 16'h1234);
		send(16'h8000, 16'h7FFF, 16'h4000);
		random_phase(100);
		set_offsets(16'h0000, 16'h0000, 16'h0000);
		random_phase(110);
		set_offsets(16'h7FFF, 16'h8000, 16'hFFFF);
		random_phase(100);
		set_offsets(AXIS_W'($urandom), AXIS_W'($urandom), AXIS_W'($urandom));
		random_phase(110);
		set_offsets(16'h0010, 16'hFFF0, 16'h0400);
		random_phase(110);
		settle();
		$display("%0d requests over six offset settings, extremes, wraps and zero vectors",
			sent);
		if (fails == 0 && pending == 0) begin
			$display("accel_tilt_angle_compute_core_tb: clean");
		end else begin
			$display("accel_tilt_angle_compute_core_tb: errors");
		end
		$finish;
	end
endmodule
